// ===== rtl/two_class_fifo_oldest_first_defines.svh =====
// ----------------------------------------------------------------------------
// Two-class FIFO, oldest-first dequeue: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_FIFO_OLDEST_FIRST_DEFINES_SVH
`define TWO_CLASS_FIFO_OLDEST_FIRST_DEFINES_SVH

// assertion with reset masking
`define TCFO_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion that also holds across reset
`define TCFO_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tcfo_pkg.sv =====
// ----------------------------------------------------------------------------
// tcfo_pkg
// Types and codes shared by the two-class FIFO modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tcfo_pkg;

  localparam int unsigned TAG_PORT_W = 32;
  localparam int unsigned TAG_MAX_W  = 48;
  localparam int unsigned STAMP_W    = 32;

  localparam logic [1:0] FN_ENQ   = 2'd0;
  localparam logic [1:0] FN_ANY   = 2'd1;
  localparam logic [1:0] FN_DEQ_A = 2'd2;
  localparam logic [1:0] FN_DEQ_B = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic CLASS_A = 1'b1;
  localparam logic CLASS_B = 1'b0;

  typedef struct packed {
    logic [1:0]            func;
    logic                  class_sel;
    logic [TAG_PORT_W-1:0] tag_in;
  } req_t;

  typedef struct packed {
    logic [TAG_PORT_W-1:0] tag_out;
    logic                  class_out;
    logic [1:0]            status;
  } rsp_t;

  typedef struct packed {
    logic rd;
    logic push;
    logic pop;
  } q_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef enum logic {
    S_IDLE,
    S_PROC
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/tcfo_queue.sv =====
// ----------------------------------------------------------------------------
// tcfo_queue
// One class queue: slot memory with registered head read, head/tail/count.
// ----------------------------------------------------------------------------
`default_nettype none

module tcfo_queue #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned SLOT_W      = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tcfo_pkg::q_ctl_t  ctl,
  input  wire logic [SLOT_W-1:0] wr_data,
  output logic      [SLOT_W-1:0] head_data,
  output tcfo_pkg::q_stat_t      stat
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  logic [SLOT_W-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  tail;
  logic [CNT_W-1:0]  count;
  logic [PTR_W-1:0]  head_next;
  logic [PTR_W-1:0]  tail_next;
  logic [CNT_W-1:0]  count_next;

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    if (ctl.pop) begin
      head_next  = (head == LAST) ? '0 : head + 1'b1;
      count_next = count - 1'b1;
    end
    if (ctl.push) begin
      tail_next  = (tail == LAST) ? '0 : tail + 1'b1;
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      head_data <= mem[head];
    end
  end

  assign stat.empty = (count == '0);
  assign stat.full  = (count == FULL_CNT);

endmodule

`default_nettype wire

// ===== rtl/two_class_fifo_oldest_first.sv =====
// ----------------------------------------------------------------------------
// two_class_fifo_oldest_first
// Two class queues with a shared arrival stamp; dequeue-any pops the older.
// ----------------------------------------------------------------------------
// Each command word runs as follows: on the accepting edge both queue memories
// read their head slot, and in the following cycle (busy high) the heads are
// compared, pointers and counter updated and any enqueue written. The result
// word is on rsp with done high for exactly the next cycle, when a new
// command may already be accepted. The receiver cannot stall: it must take
// every result word in the cycle it is shown. Memory contents need no clear.
`default_nettype none

module two_class_fifo_oldest_first #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TAG_WIDTH   = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire tcfo_pkg::req_t req,
  output logic                done,
  output tcfo_pkg::rsp_t      rsp
);

  localparam int unsigned SLOT_W = TAG_WIDTH + tcfo_pkg::STAMP_W;

  tcfo_pkg::state_t  state;
  tcfo_pkg::state_t  state_next;
  tcfo_pkg::req_t    cmd;
  tcfo_pkg::rsp_t    rsp_next;
  tcfo_pkg::q_ctl_t  qa_ctl;
  tcfo_pkg::q_ctl_t  qb_ctl;
  tcfo_pkg::q_stat_t qa_stat;
  tcfo_pkg::q_stat_t qb_stat;

  logic [tcfo_pkg::STAMP_W-1:0]   arrival;
  logic [tcfo_pkg::STAMP_W-1:0]   stamp_diff;
  logic [SLOT_W-1:0]              qa_head;
  logic [SLOT_W-1:0]              qb_head;
  logic [SLOT_W-1:0]              wr_slot;
  logic [tcfo_pkg::TAG_MAX_W-1:0] tag_in_ext;
  logic [tcfo_pkg::TAG_MAX_W-1:0] tag_a_ext;
  logic [tcfo_pkg::TAG_MAX_W-1:0] tag_b_ext;
  logic                           accept;
  logic                           proc;
  logic                           take_a;
  logic                           bump;

  assign accept = start && !busy;
  assign proc   = (state == tcfo_pkg::S_PROC);

  always_comb begin
    state_next = state;
    case (state)
      tcfo_pkg::S_IDLE: if (accept) state_next = tcfo_pkg::S_PROC;
      tcfo_pkg::S_PROC: state_next = tcfo_pkg::S_IDLE;
      default:          state_next = tcfo_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      tcfo_pkg::S_PROC: busy = 1'b1;
      default:          busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= tcfo_pkg::S_IDLE;
      done    <= 1'b0;
      arrival <= '0;
    end else begin
      state <= state_next;
      done  <= proc;
      if (bump) arrival <= arrival + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) cmd <= req;
    if (proc)   rsp <= rsp_next;
  end

  assign tag_in_ext = tcfo_pkg::TAG_MAX_W'(cmd.tag_in);
  assign wr_slot    = {arrival, tag_in_ext[TAG_WIDTH-1:0]};
  assign tag_a_ext  = tcfo_pkg::TAG_MAX_W'(qa_head[TAG_WIDTH-1:0]);
  assign tag_b_ext  = tcfo_pkg::TAG_MAX_W'(qb_head[TAG_WIDTH-1:0]);
  assign stamp_diff = qa_head[SLOT_W-1:TAG_WIDTH] - qb_head[SLOT_W-1:TAG_WIDTH];

  // decision and result for the word in flight
  always_comb begin
    rsp_next   = '0;
    qa_ctl     = '0;
    qb_ctl     = '0;
    qa_ctl.rd  = accept;
    qb_ctl.rd  = accept;
    bump       = 1'b0;
    take_a     = 1'b0;
    case (cmd.func)
      tcfo_pkg::FN_ENQ:   take_a = 1'b0;
      tcfo_pkg::FN_DEQ_A: take_a = 1'b1;
      tcfo_pkg::FN_DEQ_B: take_a = 1'b0;
      default: begin
        if (!qa_stat.empty && !qb_stat.empty) begin
          take_a = stamp_diff[tcfo_pkg::STAMP_W-1];
        end else begin
          take_a = !qa_stat.empty;
        end
      end
    endcase
    if (cmd.func == tcfo_pkg::FN_ENQ) begin
      if (cmd.class_sel == tcfo_pkg::CLASS_A) begin
        if (qa_stat.full) begin
          rsp_next.status = tcfo_pkg::ST_FULL;
        end else begin
          qa_ctl.push = proc;
          bump        = proc;
        end
      end else begin
        if (qb_stat.full) begin
          rsp_next.status = tcfo_pkg::ST_FULL;
        end else begin
          qb_ctl.push = proc;
          bump        = proc;
        end
      end
    end else if (take_a) begin
      if (qa_stat.empty) begin
        rsp_next.status = tcfo_pkg::ST_EMPTY;
      end else begin
        qa_ctl.pop         = proc;
        rsp_next.tag_out   = tag_a_ext[tcfo_pkg::TAG_PORT_W-1:0];
        rsp_next.class_out = tcfo_pkg::CLASS_A;
      end
    end else begin
      if (qb_stat.empty) begin
        rsp_next.status = tcfo_pkg::ST_EMPTY;
      end else begin
        qb_ctl.pop         = proc;
        rsp_next.tag_out   = tag_b_ext[tcfo_pkg::TAG_PORT_W-1:0];
        rsp_next.class_out = tcfo_pkg::CLASS_B;
      end
    end
  end

  tcfo_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .SLOT_W     (SLOT_W)
  ) u_queue_a (
    .clk      (clk),
    .rst      (rst),
    .ctl      (qa_ctl),
    .wr_data  (wr_slot),
    .head_data(qa_head),
    .stat     (qa_stat)
  );

  tcfo_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .SLOT_W     (SLOT_W)
  ) u_queue_b (
    .clk      (clk),
    .rst      (rst),
    .ctl      (qb_ctl),
    .wr_data  (wr_slot),
    .head_data(qb_head),
    .stat     (qb_stat)
  );

endmodule

`default_nettype wire

// ===== rtl/tcfo_checker.sv =====
// ----------------------------------------------------------------------------
// tcfo_checker
// Port-level timing and result checks, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_class_fifo_oldest_first_defines.svh"

module tcfo_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           done,
  input wire tcfo_pkg::rsp_t rsp
);

  `TCFO_ASSERT(a_word_done, clk, rst, start && !busy |-> ##2 done, "accepted word gave no result")
  `TCFO_ASSERT(a_done_cause, clk, rst, done |-> $past(start && !busy, 2), "result without a command")
  `TCFO_ASSERT(a_no_pop_data, clk, rst, done && rsp.status != tcfo_pkg::ST_OK |-> rsp.tag_out == '0 && rsp.class_out == 1'b0, "failed word carries data")
  `TCFO_ASSERT_NR(a_reset_quiet, clk, rst |=> !done && !busy, "activity right after reset")

endmodule

bind two_class_fifo_oldest_first tcfo_checker u_tcfo_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done),
  .rsp  (rsp)
);

`default_nettype wire
